### sv/set_assoc_lru_cache_tags_assert.svh
// Assertion macros shared by the cache tag controller.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/slc_pkg.sv
// Shared constants and types of the cache tag controller.
package slc_pkg;

    localparam int NUM_SETS   = 64;
    localparam int NUM_WAYS   = 4;
    localparam int LINE_BYTES = 16;
    localparam int ADDR_WIDTH = 32;

    localparam int OFF_BITS    = $clog2(LINE_BYTES);
    localparam int SET_BITS    = $clog2(NUM_SETS);
    localparam int TAG_BITS    = ADDR_WIDTH - OFF_BITS - SET_BITS;
    localparam int WAY_BITS    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_BITS    = WAY_BITS;
    localparam int ENTRY_BITS  = SET_BITS + WAY_BITS;
    localparam int ENTRIES     = 1 << ENTRY_BITS;
    localparam int META_BITS   = TAG_BITS + 1 + AGE_BITS;

    // Fixed field widths of the channels
    localparam int IN_ADDR_BITS  = 32;
    localparam int WAY_OUT_BITS  = 2;
    localparam int VTAG_BITS     = 22;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WB_MODE     = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WRITE_ALLOC = 1'd1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(NUM_WAYS - 1);
    localparam logic [WAY_BITS-1:0] LAST_WAY = WAY_BITS'(NUM_WAYS - 1);

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                dirty;
        logic [AGE_BITS-1:0] age;
    } line_meta_t;

    // One way of the set, presented to the compare unit
    typedef struct packed {
        logic                clear;
        logic                vld;
        logic [WAY_BITS-1:0] way;
        logic                line_valid;
        logic [TAG_BITS-1:0] ref_tag;
        line_meta_t          meta;
    } way_beat_t;

    // Running lookup result over the ways seen so far
    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] hit_way;
        logic [AGE_BITS-1:0] hit_age;
        logic                free;
        logic [WAY_BITS-1:0] free_way;
        logic [WAY_BITS-1:0] lru_way;
        logic [AGE_BITS-1:0] lru_age;
        logic [TAG_BITS-1:0] lru_tag;
        logic                lru_dirty;
    } lookup_t;

endpackage

### sv/slc_ifs.sv
// Request and response channel interfaces of the cache tag controller.
interface slc_req_if;
    import slc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [IN_ADDR_BITS-1:0] access_address;

    modport source (output valid, output mode, output access_address, input ready);
    modport sink   (input valid, input mode, input access_address, output ready);
endinterface

interface slc_rsp_if;
    import slc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    is_hit;
    logic [WAY_OUT_BITS-1:0] way_used;
    logic                    allocated;
    logic                    evicted;
    logic                    dirty_writeback;
    logic [VTAG_BITS-1:0]    victim_tag;
    logic                    memory_write;

    modport source (
        output valid, output is_hit, output way_used, output allocated, output evicted,
        output dirty_writeback, output victim_tag, output memory_write, input ready
    );
    modport sink (
        input valid, input is_hit, input way_used, input allocated, input evicted,
        input dirty_writeback, input victim_tag, input memory_write, output ready
    );
endinterface

### sv/slc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/slc_way_eval.sv
// Shared tag/age compare unit: folds one way per cycle into the lookup result.
module slc_way_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  slc_pkg::way_beat_t beat,
    output slc_pkg::lookup_t   look
);
    import slc_pkg::*;

    logic                hit_reg;
    logic [WAY_BITS-1:0] hit_way_reg;
    logic [AGE_BITS-1:0] hit_age_reg;
    logic                free_reg;
    logic [WAY_BITS-1:0] free_way_reg;
    logic [WAY_BITS-1:0] lru_way_reg;
    logic [AGE_BITS-1:0] lru_age_reg;
    logic [TAG_BITS-1:0] lru_tag_reg;
    logic                lru_dirty_reg;
    logic                match;

    assign match = beat.line_valid && (beat.meta.tag == beat.ref_tag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            hit_way_reg  <= '0;
            hit_age_reg  <= '0;
            free_reg     <= 1'b0;
            free_way_reg <= '0;
            lru_way_reg  <= '0;
            lru_age_reg  <= '0;
        end
        else if (beat.clear)
        begin
            hit_reg      <= 1'b0;
            hit_way_reg  <= '0;
            hit_age_reg  <= '0;
            free_reg     <= 1'b0;
            free_way_reg <= '0;
            lru_way_reg  <= '0;
            lru_age_reg  <= '0;
        end
        else if (beat.vld)
        begin
            if (match && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_way_reg <= beat.way;
                hit_age_reg <= beat.meta.age;
            end
            if (!beat.line_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_way_reg <= beat.way;
            end
            // >= so that ties go to the higher way
            if (beat.meta.age >= lru_age_reg)
            begin
                lru_age_reg <= beat.meta.age;
                lru_way_reg <= beat.way;
            end
        end
    end

    // Victim tag and dirty bit follow the way picked above
    always_ff @(posedge clk)
    begin
        if (!beat.clear && beat.vld && (beat.meta.age >= lru_age_reg))
        begin
            lru_tag_reg   <= beat.meta.tag;
            lru_dirty_reg <= beat.meta.dirty;
        end
    end

    always_comb
    begin
        look.hit       = hit_reg;
        look.hit_way   = hit_way_reg;
        look.hit_age   = hit_age_reg;
        look.free      = free_reg;
        look.free_way  = free_way_reg;
        look.lru_way   = lru_way_reg;
        look.lru_age   = lru_age_reg;
        look.lru_tag   = lru_tag_reg;
        look.lru_dirty = lru_dirty_reg;
    end

endmodule

### sv/set_assoc_lru_cache_tags.sv
// Top level: tag and LRU state controller of a set-associative cache.
//
//   channel | dir | beat payload
//   --------+-----+-----------------------------------------------------------
//   req     | in  | mode, access_address
//   rsp     | out | is_hit, way_used, allocated, evicted, dirty_writeback,
//           |     | victim_tag, memory_write
//   cfg_*   | in  | write enable, register index, data (no handshake)
//
// After an accepted request, rsp.valid rises once these steps are through: a scan
// that feeds the shared compare unit one way at a time, a decide step, a RAM write
// pass over the ways (skipped on a no-allocate write miss), and the response load.
// req.ready returns with the response load, so no new access is taken before the
// last one is done; a held response stalls only the next response load.
// Reset empties the cache at once through per-line valid flops; no clearing pass.
module set_assoc_lru_cache_tags (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [slc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [slc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    slc_req_if.sink                            req,
    slc_rsp_if.source                          rsp
);
    import slc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_WRITE  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [WAY_BITS:0]   wcnt_reg, wcnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [WAY_BITS-1:0] rd_way_reg, rd_way_next;

    logic                mode_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [SET_BITS-1:0] set_reg;
    logic                wb_mode_reg;
    logic                wa_mode_reg;

    logic [ENTRIES-1:0]  valid_reg;
    line_meta_t          meta_buf_reg [NUM_WAYS];
    logic [NUM_WAYS-1:0] vbuf_reg;

    logic                    dec_hit_reg;
    logic                    dec_touch_reg;
    logic                    dec_alloc_reg;
    logic                    dec_evict_reg;
    logic                    dec_wb_reg;
    logic                    dec_mw_reg;
    logic [WAY_BITS-1:0]     dec_tgt_reg;
    logic [VTAG_BITS-1:0]    dec_vtag_reg;

    logic                    rsp_valid_reg;
    logic                    out_hit_reg;
    logic [WAY_OUT_BITS-1:0] out_way_reg;
    logic                    out_alloc_reg;
    logic                    out_evict_reg;
    logic                    out_wb_reg;
    logic [VTAG_BITS-1:0]    out_vtag_reg;
    logic                    out_mw_reg;

    logic                    accept;
    logic                    rsp_load;
    logic [ENTRY_BITS-1:0]   rd_entry;
    logic                    rd_line_valid;
    line_meta_t              rd_meta;
    logic [META_BITS-1:0]    ram_rdata;
    logic                    ram_we;
    logic [ENTRY_BITS-1:0]   ram_addr;
    way_beat_t               beat;
    lookup_t                 look;

    logic                    is_write;
    logic                    touch;
    logic                    alloc;
    logic                    evict;
    logic [WAY_BITS-1:0]     tgt;
    logic [WAY_BITS:0]       old_age;
    line_meta_t              meta_upd [NUM_WAYS];

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    // Reads and writes never overlap, so one address serves both ports
    assign ram_addr = {set_reg, wcnt_reg[WAY_BITS-1:0]};
    assign ram_we   = (state_reg == S_WRITE) &&
                      (vbuf_reg[wcnt_reg[WAY_BITS-1:0]] ||
                       (wcnt_reg[WAY_BITS-1:0] == dec_tgt_reg));

    slc_ram #(
        .WIDTH (META_BITS),
        .DEPTH (ENTRIES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (meta_buf_reg[wcnt_reg[WAY_BITS-1:0]]),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Lines never written read back as clean, age zero
    assign rd_entry      = {set_reg, rd_way_reg};
    assign rd_line_valid = valid_reg[rd_entry];
    assign rd_meta       = rd_line_valid ? line_meta_t'(ram_rdata) : '0;

    always_comb
    begin
        beat.clear      = accept;
        beat.vld        = rd_pend_reg && (state_reg == S_SCAN);
        beat.way        = rd_way_reg;
        beat.line_valid = rd_line_valid;
        beat.ref_tag    = tag_reg;
        beat.meta       = rd_meta;
    end

    slc_way_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .look  (look)
    );

    // Decision and LRU age update for the whole set
    always_comb
    begin
        is_write = (mode_reg == MODE_WRITE);
        touch    = look.hit || !is_write || wa_mode_reg;
        alloc    = !look.hit && touch;
        evict    = alloc && !look.free;
        if (look.hit)
        begin
            tgt     = look.hit_way;
            old_age = {1'b0, look.hit_age};
        end
        else if (look.free)
        begin
            tgt     = look.free_way;
            old_age = (WAY_BITS + 1)'(NUM_WAYS);
        end
        else
        begin
            tgt     = look.lru_way;
            old_age = {1'b0, look.lru_age};
        end
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            meta_upd[i] = meta_buf_reg[i];
            if (WAY_BITS'(i) == tgt)
            begin
                meta_upd[i].age = '0;
                if (alloc)
                begin
                    meta_upd[i].tag   = tag_reg;
                    meta_upd[i].dirty = 1'b0;
                end
                if (is_write && wb_mode_reg)
                begin
                    meta_upd[i].dirty = 1'b1;
                end
            end
            else if (vbuf_reg[i] && ({1'b0, meta_buf_reg[i].age} < old_age) &&
                     (meta_buf_reg[i].age < AGE_MAX))
            begin
                meta_upd[i].age = meta_buf_reg[i].age + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        wcnt_next    = wcnt_reg;
        rd_pend_next = 1'b0;
        rd_way_next  = rd_way_reg;
        case (state_reg)
            S_IDLE:
            begin
                wcnt_next = '0;
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (wcnt_reg < (WAY_BITS + 1)'(NUM_WAYS))
                begin
                    rd_pend_next = 1'b1;
                    rd_way_next  = wcnt_reg[WAY_BITS-1:0];
                    wcnt_next    = wcnt_reg + 1'b1;
                end
                if (rd_pend_reg && (rd_way_reg == LAST_WAY))
                begin
                    state_next   = S_DECIDE;
                    rd_pend_next = 1'b0;
                    wcnt_next    = '0;
                end
            end
            S_DECIDE:
            begin
                wcnt_next  = '0;
                state_next = touch ? S_WRITE : S_DONE;
            end
            S_WRITE:
            begin
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg[WAY_BITS-1:0] == LAST_WAY)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wcnt_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            rd_way_reg    <= '0;
            wb_mode_reg   <= 1'b1;
            wa_mode_reg   <= 1'b1;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wcnt_reg    <= wcnt_next;
            rd_pend_reg <= rd_pend_next;
            rd_way_reg  <= rd_way_next;
            if (cfg_we && (cfg_index == REG_WB_MODE))
            begin
                wb_mode_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == REG_WRITE_ALLOC))
            begin
                wa_mode_reg <= cfg_data[0];
            end
            if ((state_reg == S_DECIDE) && alloc)
            begin
                valid_reg[{set_reg, tgt}] <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            set_reg  <= req.access_address[OFF_BITS +: SET_BITS];
            tag_reg  <= req.access_address[ADDR_WIDTH-1 -: TAG_BITS];
        end
        if (beat.vld)
        begin
            meta_buf_reg[rd_way_reg] <= rd_meta;
            vbuf_reg[rd_way_reg]     <= rd_line_valid;
        end
        if (state_reg == S_DECIDE)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                meta_buf_reg[i] <= meta_upd[i];
            end
            dec_hit_reg   <= look.hit;
            dec_touch_reg <= touch;
            dec_alloc_reg <= alloc;
            dec_evict_reg <= evict;
            dec_wb_reg    <= evict && look.lru_dirty;
            dec_mw_reg    <= is_write && (!touch || !wb_mode_reg);
            dec_tgt_reg   <= tgt;
            dec_vtag_reg  <= evict ? VTAG_BITS'(look.lru_tag) : '0;
        end
        if (rsp_load)
        begin
            out_hit_reg   <= dec_hit_reg;
            out_way_reg   <= dec_touch_reg ? WAY_OUT_BITS'(dec_tgt_reg) : '0;
            out_alloc_reg <= dec_alloc_reg;
            out_evict_reg <= dec_evict_reg;
            out_wb_reg    <= dec_wb_reg;
            out_vtag_reg  <= dec_vtag_reg;
            out_mw_reg    <= dec_mw_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.is_hit          = out_hit_reg;
    assign rsp.way_used        = out_way_reg;
    assign rsp.allocated       = out_alloc_reg;
    assign rsp.evicted         = out_evict_reg;
    assign rsp.dirty_writeback = out_wb_reg;
    assign rsp.victim_tag      = out_vtag_reg;
    assign rsp.memory_write    = out_mw_reg;

`include "set_assoc_lru_cache_tags_assert.svh"

    `SLC_ASSERT_NEXT(a_accept_scan, clk, rst_n, req.valid && req.ready, state_reg == S_SCAN, "accepted beat did not start a lookup")
    `SLC_ASSERT_NEXT(a_done_load, clk, rst_n, (state_reg == S_DONE) && !rsp_valid_reg, rsp_valid_reg && (state_reg == S_IDLE), "finished lookup not moved to response register")
    `SLC_ASSERT_NOW(a_evict_alloc, clk, rst_n, rsp.valid && rsp.evicted, rsp.allocated && !rsp.is_hit, "eviction reported without a fill on a miss")

endmodule
